// ===== rtl/dmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr_pkg
// Shared types, codes and constants of the dual motor ramp controller.
// ----------------------------------------------------------------------------
package dmr_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_MODE   = 3'd1;
    localparam logic [2:0] KIND_SPEED  = 3'd2;
    localparam logic [2:0] KIND_ADJUST = 3'd3;
    localparam logic [2:0] KIND_TURN   = 3'd4;

    // drive modes
    localparam logic [2:0] MODE_HALT    = 3'd0;
    localparam logic [2:0] MODE_FWD     = 3'd1;
    localparam logic [2:0] MODE_BACK    = 3'd2;
    localparam logic [2:0] MODE_LEFT    = 3'd3;
    localparam logic [2:0] MODE_RIGHT   = 3'd4;
    localparam logic [2:0] MODE_SPIN_BF = 3'd5;
    localparam logic [2:0] MODE_SPIN_FB = 3'd6;
    localparam logic [2:0] MODE_LAST    = MODE_SPIN_FB;

    // direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    // ramp phases
    localparam logic [1:0] PH_ACCEL = 2'd0;
    localparam logic [1:0] PH_DECEL = 2'd1;
    localparam logic [1:0] PH_SETM  = 2'd2;

    // pin patterns
    localparam logic [1:0] PINS_OFF  = 2'b00;
    localparam logic [1:0] PINS_FWD  = 2'b01;
    localparam logic [1:0] PINS_BACK = 2'b10;

    // configuration register indexes
    localparam logic [1:0] CFG_RAMP_SHIFT = 2'd0;
    localparam logic [1:0] CFG_STOP_THR   = 2'd1;
    localparam logic [1:0] CFG_PWM_TOP    = 2'd2;

    // reset values
    localparam logic [2:0]  RAMP_SHIFT_RST = 3'd2;
    localparam logic [7:0]  STOP_THR_RST   = 8'd4;
    localparam logic [15:0] PWM_TOP_RST    = 16'd4165;
    localparam logic [7:0]  BASE_RST       = 8'd100;
    localparam logic [7:0]  TURN_RST       = 8'd128;

    localparam logic [8:0]  TURN_UNITY = 9'd256;
    localparam logic [7:0]  SPEED_MAX  = 8'd255;

    // floor(x / 255) = (x * RECIP_255) >> 32 for any 24-bit x
    localparam logic [24:0] RECIP_255  = 25'd16843010;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] pdir;
        logic [1:0] wdir;
        logic [7:0] pspeed;
        logic [7:0] wspeed;
        logic [1:0] pins;
    } dmr_chan_t;

    // wanted direction per mode, ch 0 is channel A
    function automatic logic [1:0] dir_of(input logic [2:0] mode, input logic ch);
        logic [1:0] d;
        begin
            unique case (mode)
                MODE_FWD, MODE_LEFT, MODE_RIGHT: d = DIR_FWD;
                MODE_BACK:    d = DIR_BACK;
                MODE_SPIN_BF: d = ch ? DIR_FWD : DIR_BACK;
                MODE_SPIN_FB: d = ch ? DIR_BACK : DIR_FWD;
                default:      d = DIR_STOP;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== rtl/dual_motor_ramp_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_ramp_controller_top
// Two-channel motor ramp controller with a stream command input and a stream
// result output carrying PWM compare values and direction pins.
// ----------------------------------------------------------------------------
// Every accepted item (tick or command) yields exactly one result item. The
// block takes one item per cycle unless a stalled result backs it up; a result
// passes the input register (loaded at the accepting edge), state update (the
// whole ramp and command logic, so each item sees the state left by the one
// before), speed times PWM top, and divide by 255 into the output register.
// Stages hold when the output is stalled and empty stages fill, so input is
// still taken while a result waits. Configuration writes take effect at once
// and are meant for idle periods.
module dual_motor_ramp_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[2:0], speed_value[10:3], speed_delta[18:11], turn_value[26:19]
    input  logic [31:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // compare_a[15:0], compare_b[31:16], pins_a[33:32], pins_b[35:34]
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata
);

    logic [2:0]  ramp_shift_reg;
    logic [7:0]  stop_thr_reg;
    logic [15:0] pwm_top_reg;

    logic [2:0]  kind_reg;
    logic [26:0] data_reg;
    logic        in_vld_reg, upd_vld_reg, mul_vld_reg, out_vld_reg;
    logic        adv_in, adv_upd, adv_mul, adv_out;

    dmr_pkg::dmr_chan_t chan_a, chan_b;
    logic [15:0] compare_a, compare_b;
    logic [1:0]  pins_a, pins_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_shift_reg <= dmr_pkg::RAMP_SHIFT_RST;
            stop_thr_reg   <= dmr_pkg::STOP_THR_RST;
            pwm_top_reg    <= dmr_pkg::PWM_TOP_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                dmr_pkg::CFG_RAMP_SHIFT: ramp_shift_reg <= cfg_wdata[2:0];
                dmr_pkg::CFG_STOP_THR:   stop_thr_reg   <= cfg_wdata[7:0];
                dmr_pkg::CFG_PWM_TOP:    pwm_top_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline flow: a stage moves when the next one is empty or moving
    assign adv_out  = out_vld_reg && m_tready;
    assign adv_mul  = mul_vld_reg && (!out_vld_reg || adv_out);
    assign adv_upd  = upd_vld_reg && (!mul_vld_reg || adv_mul);
    assign adv_in   = in_vld_reg && (!upd_vld_reg || adv_upd);
    assign s_tready = !in_vld_reg || adv_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            upd_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (!upd_vld_reg || adv_upd) begin
                upd_vld_reg <= adv_in;
            end
            if (!mul_vld_reg || adv_mul) begin
                mul_vld_reg <= adv_upd;
            end
            if (!out_vld_reg || adv_out) begin
                out_vld_reg <= adv_mul;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg <= s_tuser;
            data_reg <= s_tdata[26:0];
        end
    end

    dmr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv_in),
        .kind        (kind_reg),
        .mode        (data_reg[2:0]),
        .speed_value (data_reg[10:3]),
        .speed_delta ($signed(data_reg[18:11])),
        .turn_value  (data_reg[26:19]),
        .ramp_shift  (ramp_shift_reg),
        .stop_thr    (stop_thr_reg),
        .chan_a      (chan_a),
        .chan_b      (chan_b)
    );

    dmr_cmp u_cmp_a (
        .aclk     (aclk),
        .en_mul   (adv_upd),
        .en_div   (adv_mul),
        .pwm_top  (pwm_top_reg),
        .speed    (chan_a.pspeed),
        .pins     (chan_a.pins),
        .compare  (compare_a),
        .pins_out (pins_a)
    );

    dmr_cmp u_cmp_b (
        .aclk     (aclk),
        .en_mul   (adv_upd),
        .en_div   (adv_mul),
        .pwm_top  (pwm_top_reg),
        .speed    (chan_b.pspeed),
        .pins     (chan_b.pins),
        .compare  (compare_b),
        .pins_out (pins_b)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, pins_b, pins_a, compare_b, compare_a};

endmodule

// ===== rtl/dmr_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr_chan
// One tick of a channel's ramp: accelerate, decelerate, switch pins.
// ----------------------------------------------------------------------------
module dmr_chan (
    input  dmr_pkg::dmr_chan_t cur,
    input  logic [2:0]         ramp_shift,
    input  logic [7:0]         stop_thr,
    output dmr_pkg::dmr_chan_t nxt
);

    logic signed [9:0] acc_diff;
    logic signed [9:0] acc_step;
    logic signed [9:0] dec_diff;
    logic signed [9:0] dec_step;
    logic [9:0]        acc_sum;
    logic [9:0]        dec_sum;

    // floor shifts; sums always stay within 0..255
    assign acc_diff = $signed({2'b00, cur.wspeed}) - $signed({2'b00, cur.pspeed});
    assign acc_step = acc_diff >>> ramp_shift;
    assign dec_diff = 10'sd0 - $signed({2'b00, cur.pspeed});
    assign dec_step = dec_diff >>> ramp_shift;
    assign acc_sum  = {2'b00, cur.pspeed} + $unsigned(acc_step);
    assign dec_sum  = {2'b00, cur.pspeed} + $unsigned(dec_step);

    always_comb begin
        nxt = cur;
        unique case (cur.phase)
            dmr_pkg::PH_DECEL: begin
                nxt.pspeed = dec_sum[7:0];
                if (cur.pspeed < stop_thr) begin
                    nxt.phase = dmr_pkg::PH_SETM;
                end
            end
            dmr_pkg::PH_SETM: begin
                unique case (cur.wdir)
                    dmr_pkg::DIR_FWD:  nxt.pins = dmr_pkg::PINS_FWD;
                    dmr_pkg::DIR_BACK: nxt.pins = dmr_pkg::PINS_BACK;
                    default: begin
                        nxt.pins   = dmr_pkg::PINS_OFF;
                        nxt.wspeed = '0;
                    end
                endcase
                nxt.pdir  = cur.wdir;
                nxt.phase = dmr_pkg::PH_ACCEL;
            end
            default: begin
                if (cur.wdir != cur.pdir) begin
                    nxt.phase = dmr_pkg::PH_DECEL;
                end else begin
                    nxt.pspeed = acc_sum[7:0];
                end
            end
        endcase
    end

endmodule

// ===== rtl/dmr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr_core
// Controller state and its combinational update for one item, registered when enabled.
// ----------------------------------------------------------------------------
module dmr_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [2:0]         kind,
    input  logic [2:0]         mode,
    input  logic [7:0]         speed_value,
    input  logic signed [7:0]  speed_delta,
    input  logic [7:0]         turn_value,
    input  logic [2:0]         ramp_shift,
    input  logic [7:0]         stop_thr,
    output dmr_pkg::dmr_chan_t chan_a,
    output dmr_pkg::dmr_chan_t chan_b
);

    logic [2:0]         drive_mode_reg, drive_mode_next;
    logic [7:0]         base_reg, base_next;
    logic [7:0]         turn_reg, turn_next;
    dmr_pkg::dmr_chan_t chan_a_reg, chan_a_next;
    dmr_pkg::dmr_chan_t chan_b_reg, chan_b_next;
    dmr_pkg::dmr_chan_t tick_a, tick_b;

    logic signed [9:0]  adj_sum;
    logic [2:0]         mode_sel;
    logic               apply;
    logic [8:0]         up_factor, dn_factor;
    logic [16:0]        up_prod, dn_prod;
    logic [7:0]         up_speed, dn_speed;

    dmr_chan u_chan_a (
        .cur        (chan_a_reg),
        .ramp_shift (ramp_shift),
        .stop_thr   (stop_thr),
        .nxt        (tick_a)
    );

    dmr_chan u_chan_b (
        .cur        (chan_b_reg),
        .ramp_shift (ramp_shift),
        .stop_thr   (stop_thr),
        .nxt        (tick_b)
    );

    assign adj_sum = $signed({2'b00, base_reg}) + 10'(speed_delta);

    always_comb begin
        base_next = base_reg;
        turn_next = turn_reg;
        unique case (kind)
            dmr_pkg::KIND_SPEED: base_next = speed_value;
            dmr_pkg::KIND_ADJUST: begin
                if (adj_sum < 0) begin
                    base_next = '0;
                end else if (adj_sum > $signed({2'b00, dmr_pkg::SPEED_MAX})) begin
                    base_next = dmr_pkg::SPEED_MAX;
                end else begin
                    base_next = adj_sum[7:0];
                end
            end
            dmr_pkg::KIND_TURN: turn_next = turn_value;
            default: ;
        endcase
    end

    always_comb begin
        if (kind == dmr_pkg::KIND_MODE) begin
            mode_sel = mode;
            apply    = (mode <= dmr_pkg::MODE_LAST);
        end else begin
            mode_sel = (drive_mode_reg > dmr_pkg::MODE_LAST) ? dmr_pkg::MODE_HALT
                                                            : drive_mode_reg;
            apply    = (kind == dmr_pkg::KIND_SPEED) || (kind == dmr_pkg::KIND_ADJUST) ||
                       (kind == dmr_pkg::KIND_TURN);
        end
    end

    assign up_factor = dmr_pkg::TURN_UNITY + {1'b0, turn_next};
    assign dn_factor = dmr_pkg::TURN_UNITY - {1'b0, turn_next};
    assign up_prod   = base_next * up_factor;
    assign dn_prod   = base_next * dn_factor;
    assign up_speed  = up_prod[16] ? dmr_pkg::SPEED_MAX : up_prod[15:8];
    assign dn_speed  = dn_prod[16] ? dmr_pkg::SPEED_MAX : dn_prod[15:8];

    always_comb begin
        drive_mode_next = drive_mode_reg;
        chan_a_next     = chan_a_reg;
        chan_b_next     = chan_b_reg;
        if (kind == dmr_pkg::KIND_TICK) begin
            chan_a_next = tick_a;
            chan_b_next = tick_b;
        end else if (apply) begin
            drive_mode_next  = mode_sel;
            chan_a_next.wdir = dmr_pkg::dir_of(mode_sel, 1'b0);
            chan_b_next.wdir = dmr_pkg::dir_of(mode_sel, 1'b1);
            unique case (mode_sel)
                dmr_pkg::MODE_LEFT: begin
                    chan_a_next.wspeed = up_speed;
                    chan_b_next.wspeed = dn_speed;
                end
                dmr_pkg::MODE_RIGHT: begin
                    chan_a_next.wspeed = dn_speed;
                    chan_b_next.wspeed = up_speed;
                end
                default: begin
                    chan_a_next.wspeed = base_next;
                    chan_b_next.wspeed = base_next;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg <= dmr_pkg::MODE_HALT;
            base_reg       <= dmr_pkg::BASE_RST;
            turn_reg       <= dmr_pkg::TURN_RST;
            chan_a_reg     <= '0;
            chan_b_reg     <= '0;
        end else if (en) begin
            drive_mode_reg <= drive_mode_next;
            base_reg       <= base_next;
            turn_reg       <= turn_next;
            chan_a_reg     <= chan_a_next;
            chan_b_reg     <= chan_b_next;
        end
    end

    assign chan_a = chan_a_reg;
    assign chan_b = chan_b_reg;

endmodule

// ===== rtl/dmr_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr_cmp
// PWM compare for one channel: top * speed, then divide by 255 through a
// reciprocal multiply. Two register stages, pins carried alongside.
// ----------------------------------------------------------------------------
module dmr_cmp (
    input  logic        aclk,
    input  logic        en_mul,
    input  logic        en_div,
    input  logic [15:0] pwm_top,
    input  logic [7:0]  speed,
    input  logic [1:0]  pins,
    output logic [15:0] compare,
    output logic [1:0]  pins_out
);

    logic [23:0] prod_reg;
    logic [1:0]  pins_mid_reg;
    logic [15:0] compare_reg;
    logic [1:0]  pins_out_reg;
    logic [48:0] quot_wide;

    // zero speed or zero top give a zero product, hence a zero compare
    assign quot_wide = prod_reg * dmr_pkg::RECIP_255;

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_reg     <= pwm_top * speed;
            pins_mid_reg <= pins;
        end
        if (en_div) begin
            compare_reg  <= quot_wide[47:32];
            pins_out_reg <= pins_mid_reg;
        end
    end

    assign compare  = compare_reg;
    assign pins_out = pins_out_reg;

endmodule

// ===== rtl/dmr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr_checker
// Port-level checks of the dual motor ramp controller, bound to the top.
// ----------------------------------------------------------------------------
module dmr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input only backs up behind a waiting result
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a channel never drives both direction lines
    a_pins_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] != 2'b11) && (m_tdata[35:34] != 2'b11))
        else $error("both direction lines high");

endmodule

bind dual_motor_ramp_controller_top dmr_checker u_dmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/dmr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_ramp_checker
// Watches the command and result streams of the dual motor ramp controller.
// It keeps its own copy of the drive state and the registers, predicts the
// result of every accepted item, and compares each result field by field.
// ----------------------------------------------------------------------------
module motor_ramp_checker
    import dmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        logic [1:0]  pins_a;
        logic [1:0]  pins_b;
    } drive_out_t;

    drive_out_t drive_outputs[$];
    int         mismatches;

    // registers
    logic [2:0]  ramp_sh;
    logic [7:0]  stop_thr;
    logic [15:0] pwm_top;

    // drive state, index 0 is channel A
    logic [2:0]  cur_mode;
    logic [7:0]  base_spd;
    logic [7:0]  turn_fac;
    logic [1:0]  ramp_ph[2];
    logic [1:0]  cur_dir[2];
    logic [1:0]  tgt_dir[2];
    logic [7:0]  cur_spd[2];
    logic [7:0]  tgt_spd[2];
    logic [1:0]  pin_state[2];

    assign fail_count = mismatches;

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [7:0] clip8(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [1:0] mode_dir(input logic [2:0] m, input int ch);
        case (m)
            MODE_FWD, MODE_LEFT, MODE_RIGHT: return DIR_FWD;
            MODE_BACK:    return DIR_BACK;
            MODE_SPIN_BF: return (ch == 0) ? DIR_BACK : DIR_FWD;
            MODE_SPIN_FB: return (ch == 0) ? DIR_FWD : DIR_BACK;
            default:      return DIR_STOP;
        endcase
    endfunction

    function automatic logic [15:0] duty_of(input logic [7:0] spd);
        if (spd == 8'd0) return 16'd0;
        return 16'((int'(pwm_top) * int'(spd)) / 255);
    endfunction

    task automatic set_targets(input logic [2:0] m);
        int up;
        int dn;
        up = (int'(base_spd) * (256 + int'(turn_fac))) >> 8;
        dn = (int'(base_spd) * (256 - int'(turn_fac))) >> 8;
        for (int c = 0; c < 2; c++) begin
            tgt_dir[c] = mode_dir(m, c);
            tgt_spd[c] = base_spd;
        end
        if (m == MODE_LEFT) begin
            tgt_spd[0] = clip8(up);
            tgt_spd[1] = clip8(dn);
        end else if (m == MODE_RIGHT) begin
            tgt_spd[0] = clip8(dn);
            tgt_spd[1] = clip8(up);
        end
        cur_mode = m;
    endtask

    task automatic ramp_channel(input int c);
        int cur;
        int err;
        cur = int'(cur_spd[c]);
        if (ramp_ph[c] == PH_DECEL) begin
            err = -cur;
            cur_spd[c] = clip8(cur + (err >>> ramp_sh));
            if (cur < int'(stop_thr)) ramp_ph[c] = PH_SETM;
        end else if (ramp_ph[c] == PH_SETM) begin
            if (tgt_dir[c] == DIR_FWD) begin
                pin_state[c] = PINS_FWD;
            end else if (tgt_dir[c] == DIR_BACK) begin
                pin_state[c] = PINS_BACK;
            end else begin
                pin_state[c] = PINS_OFF;
                tgt_spd[c] = 8'd0;
            end
            cur_dir[c] = tgt_dir[c];
            ramp_ph[c] = PH_ACCEL;
        end else begin
            if (tgt_dir[c] != cur_dir[c]) begin
                ramp_ph[c] = PH_DECEL;
            end else begin
                err = int'(tgt_spd[c]) - cur;
                cur_spd[c] = clip8(cur + (err >>> ramp_sh));
            end
        end
    endtask

    // one accepted item: update the drive state and return the resulting outputs
    task automatic predict_drive(input logic [2:0] kind, input logic [31:0] data,
                                 output drive_out_t res);
        logic [2:0] m;
        logic [7:0] spd;
        logic [7:0] dlt;
        logic [7:0] trn;
        m   = data[2:0];
        spd = data[10:3];
        dlt = data[18:11];
        trn = data[26:19];
        case (kind)
            KIND_TICK: begin
                ramp_channel(0);
                ramp_channel(1);
            end
            KIND_MODE: begin
                if (m <= MODE_LAST) set_targets(m);
            end
            KIND_SPEED: begin
                base_spd = spd;
                set_targets(cur_mode);
            end
            KIND_ADJUST: begin
                base_spd = clip8(int'(base_spd) + int'($signed(dlt)));
                set_targets(cur_mode);
            end
            KIND_TURN: begin
                turn_fac = trn;
                set_targets(cur_mode);
            end
            default: ;
        endcase
        res.cmp_a  = duty_of(cur_spd[0]);
        res.cmp_b  = duty_of(cur_spd[1]);
        res.pins_a = pin_state[0];
        res.pins_b = pin_state[1];
    endtask

    task automatic check_result(input logic [39:0] data);
        drive_out_t got;
        drive_out_t want;
        got.cmp_a  = data[15:0];
        got.cmp_b  = data[31:16];
        got.pins_a = data[33:32];
        got.pins_b = data[35:34];
        if (drive_outputs.size() == 0) begin
            report_mismatch($sformatf("result with none expected: %h", data));
            return;
        end
        want = drive_outputs.pop_front();
        if (got.cmp_a !== want.cmp_a)
            report_mismatch($sformatf("compare_a got %0d exp %0d", got.cmp_a, want.cmp_a));
        if (got.cmp_b !== want.cmp_b)
            report_mismatch($sformatf("compare_b got %0d exp %0d", got.cmp_b, want.cmp_b));
        if (got.pins_a !== want.pins_a)
            report_mismatch($sformatf("pins_a got %b exp %b", got.pins_a, want.pins_a));
        if (got.pins_b !== want.pins_b)
            report_mismatch($sformatf("pins_b got %b exp %b", got.pins_b, want.pins_b));
    endtask

    always @(posedge aclk) begin
        drive_out_t res;
        if (!aresetn) begin
            ramp_sh  = RAMP_SHIFT_RST;
            stop_thr = STOP_THR_RST;
            pwm_top  = PWM_TOP_RST;
            cur_mode = MODE_HALT;
            base_spd = BASE_RST;
            turn_fac = TURN_RST;
            for (int c = 0; c < 2; c++) begin
                ramp_ph[c]   = PH_ACCEL;
                cur_dir[c]   = DIR_STOP;
                tgt_dir[c]   = DIR_STOP;
                cur_spd[c]   = 8'd0;
                tgt_spd[c]   = 8'd0;
                pin_state[c] = PINS_OFF;
            end
            drive_outputs.delete();
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_RAMP_SHIFT: ramp_sh  = cfg_wdata[2:0];
                    CFG_STOP_THR:   stop_thr = cfg_wdata[7:0];
                    CFG_PWM_TOP:    pwm_top  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_drive(s_tuser, s_tdata, res);
                drive_outputs.push_back(res);
            end
        end
        pending <= drive_outputs.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and drive commands into the dual motor ramp controller under
// several register settings, with random gaps on both streams and one long
// result hold-off. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import dmr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_PER_SET = 215;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_wdata;

    int fail_count;
    int pending;
    int n_sent;
    int cycles;

    dual_motor_ramp_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    motor_ramp_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // no idling on either side in this window
    function automatic bit calm();
        return n_sent >= 700 && n_sent < 850;
    endfunction

    task automatic send_item(input logic [2:0] kind, input logic [2:0] m,
                             input logic [7:0] spd, input logic [7:0] dlt,
                             input logic [7:0] trn);
        while (!calm() && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, trn, dlt, spd, m};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic send_random();
        int r;
        logic [2:0] kind;
        logic [2:0] m;
        r = $urandom_range(99);
        m = 3'($urandom_range(7));
        if (r < 58) kind = KIND_TICK;
        else if (r < 72) kind = KIND_MODE;
        else if (r < 82) kind = KIND_SPEED;
        else if (r < 90) kind = KIND_ADJUST;
        else if (r < 96) kind = KIND_TURN;
        else kind = 3'($urandom_range(5, 7));
        if (kind == KIND_MODE && m == 3'd7 && $urandom_range(3) != 0)
            m = 3'($urandom_range(6));
        send_item(kind, m, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_regs(input logic [2:0] shift, input logic [7:0] thr,
                              input logic [15:0] top);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_RAMP_SHIFT;
        cfg_wdata <= 16'(shift);
        @(posedge aclk);
        cfg_idx   <= CFG_STOP_THR;
        cfg_wdata <= 16'(thr);
        @(posedge aclk);
        cfg_idx   <= CFG_PWM_TOP;
        cfg_wdata <= top;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic random_set(input logic [2:0] shift, input logic [7:0] thr,
                              input logic [15:0] top);
        drain();
        write_regs(shift, thr, top);
        repeat (RAND_PER_SET) send_random();
    endtask

    // result side: random stalls, one long hold-off while input keeps coming
    initial begin
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (120) @(posedge aclk);
            end
            m_tready <= calm() || $urandom_range(99) >= 11;
            @(posedge aclk);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        n_sent    = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_TICK;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_RAMP_SHIFT;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset register values
        send_item(KIND_TICK, MODE_HALT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_MODE, MODE_FWD, 8'd0, 8'd0, 8'd0);
        repeat (3) send_item(KIND_TICK, 3'd7, 8'hff, 8'hff, 8'hff);
        send_item(KIND_SPEED, MODE_HALT, 8'd255, 8'd0, 8'd0);
        repeat (2) send_item(KIND_TICK, MODE_HALT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_ADJUST, MODE_HALT, 8'd0, 8'sd127, 8'd0);
        send_item(KIND_TURN, MODE_HALT, 8'd0, 8'd0, 8'd255);
        send_item(KIND_MODE, MODE_LEFT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_TICK, MODE_HALT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_MODE, MODE_RIGHT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_ADJUST, MODE_HALT, 8'd0, 8'h80, 8'd0);
        send_item(KIND_ADJUST, MODE_HALT, 8'd0, 8'h80, 8'd0);
        send_item(KIND_SPEED, MODE_HALT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_MODE, 3'd7, 8'd0, 8'd0, 8'd0);
        send_item(3'd5, MODE_BACK, 8'd9, 8'd9, 8'd9);
        send_item(3'd7, MODE_BACK, 8'hff, 8'hff, 8'hff);
        send_item(KIND_SPEED, MODE_HALT, 8'd60, 8'd0, 8'd0);
        send_item(KIND_MODE, MODE_SPIN_BF, 8'd0, 8'd0, 8'd0);
        repeat (2) send_item(KIND_TICK, MODE_HALT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_MODE, MODE_BACK, 8'd0, 8'd0, 8'd0);
        send_item(KIND_MODE, MODE_SPIN_FB, 8'd0, 8'd0, 8'd0);
        send_item(KIND_MODE, MODE_HALT, 8'd0, 8'd0, 8'd0);
        send_item(KIND_TICK, MODE_HALT, 8'd0, 8'd0, 8'd0);

        random_set(3'd0, 8'd0, 16'd1);
        random_set(3'd7, 8'd255, 16'd65535);
        random_set(3'd1, 8'd4, 16'd0);
        random_set(3'd3, 8'($urandom), 16'($urandom_range(65535, 1)));
        random_set(RAMP_SHIFT_RST, STOP_THR_RST, PWM_TOP_RST);
        random_set(3'd5, 8'd16, 16'd1000);
        drain();

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dmr_pkg.sv
rtl/dmr_chan.sv
rtl/dmr_core.sv
rtl/dmr_cmp.sv
rtl/dual_motor_ramp_controller_top.sv
rtl/dmr_checker.sv
test/dmr_checker.sv
test/testbench.sv
